@@ rtl/pubn_pkg.sv @@
// Shared types and constants for the planar UV bounding-box normalizer.
// Used by pubn_div and planar_uv_bbox_normalize; no dependencies.
package pubn_pkg;

    // Coordinate and UV widths
    localparam int COORD_W = 32;
    localparam int UV_W    = 17;

    // Store depth default
    localparam int MAX_VERTICES_DEFAULT = 64;

    // 1.0 in Q16.16, used as divisor for a flat axis
    localparam logic [COORD_W-1:0] ONE_Q16 = 32'd65536;

    // Bounding box reset values
    localparam logic signed [COORD_W-1:0] BOX_MIN_RESET = 32'sh7FFF_FFFF;
    localparam logic signed [COORD_W-1:0] BOX_MAX_RESET = 32'sh8000_0000;

    // Quotient bits produced by the divider: one integer bit and 16 fraction bits
    localparam int DIV_STEPS = UV_W;

endpackage

@@ rtl/planar_uv_bbox_normalize.sv @@
// Planar UV bounding-box normalizer, top level.
// Depends on pubn_pkg, pubn_ram and pubn_div.
//
// Input channel (vertex_valid / vertex_stall): one signed Q16.16 vertex per
// item; mesh_end marks the last vertex of a mesh. Vertices load at one per
// cycle into a MAX_VERTICES-deep store while the bounding box is tracked;
// vertices beyond the store depth are dropped and flag overflowed.
// After the mesh_end item the input stalls and the block emits one UV item
// per stored vertex on the output channel (coord_valid / coord_stall), in
// arrival order, with run_end on the last one. Then it takes a new mesh.
// Emission first sets up the ranges, then takes each vertex in turn:
// one store read, an operand step, two divisions on the shared
// restoring divider (17 quotient steps and a done cycle each, u then v),
// and the hand-off to the output register.
// A finished UV waits in the output register while the next vertex is
// divided; a stalled receiver holds the sequencer only at the hand-off.
// Reset empties the store, resets the box and drops any pending output.
module planar_uv_bbox_normalize #(
    parameter int MAX_VERTICES = pubn_pkg::MAX_VERTICES_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 vertex_valid,
    output logic                                 vertex_stall,
    input  logic signed [pubn_pkg::COORD_W-1:0]  vertex_x,
    input  logic signed [pubn_pkg::COORD_W-1:0]  vertex_y,
    input  logic                                 mesh_end,
    output logic                                 coord_valid,
    input  logic                                 coord_stall,
    output logic [pubn_pkg::UV_W-1:0]            coord_u,
    output logic [pubn_pkg::UV_W-1:0]            coord_v,
    output logic                                 run_end,
    output logic                                 overflowed
);
    import pubn_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_VERTICES);

    // Sequencer states
    localparam logic [2:0] S_LOAD  = 3'd0;
    localparam logic [2:0] S_RANGE = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_START = 3'd3;
    localparam logic [2:0] S_DIV_U = 3'd4;
    localparam logic [2:0] S_DIV_V = 3'd5;
    localparam logic [2:0] S_PUSH  = 3'd6;

    logic [2:0] state_reg, state_next;

    logic signed [COORD_W-1:0] min_x_reg, min_x_next;
    logic signed [COORD_W-1:0] max_x_reg, max_x_next;
    logic signed [COORD_W-1:0] min_y_reg, min_y_next;
    logic signed [COORD_W-1:0] max_y_reg, max_y_next;
    logic [CW-1:0]             count_reg, count_next;
    logic                      drop_reg, drop_next;
    logic [CW-1:0]             idx_reg, idx_next;

    logic [COORD_W-1:0] rx_reg, rx_next;
    logic [COORD_W-1:0] ry_reg, ry_next;
    logic [COORD_W-1:0] dy_reg, dy_next;
    logic [UV_W-1:0]    u_reg, u_next;

    logic            out_valid_reg, out_valid_next;
    logic [UV_W-1:0] out_u_reg, out_u_next;
    logic [UV_W-1:0] out_v_reg, out_v_next;
    logic            out_last_reg, out_last_next;
    logic            out_ovf_reg, out_ovf_next;

    logic                 accept;
    logic                 full;
    logic                 ram_we;
    logic                 ram_re;
    logic [2*COORD_W-1:0] ram_rdata;
    logic [COORD_W-1:0]   range_x;
    logic [COORD_W-1:0]   range_y;
    logic [COORD_W-1:0]   dx;
    logic                 out_free;
    logic                 run_last;

    logic                 div_start;
    logic [COORD_W-1:0]   div_num;
    logic [COORD_W-1:0]   div_den;
    logic                 div_done;
    logic [UV_W-1:0]      div_quot;

    // Input handshake and store write
    assign vertex_stall = (state_reg != S_LOAD);
    assign accept       = vertex_valid && !vertex_stall;
    assign full         = (count_reg == FULL_COUNT);
    assign ram_we       = accept && !full;
    assign ram_re       = (state_reg == S_READ);

    pubn_ram #(
        .WIDTH (2 * COORD_W),
        .DEPTH (MAX_VERTICES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata ({vertex_x, vertex_y}),
        .re    (ram_re),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    pubn_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // Ranges are exact in 32 bits once at least one vertex is stored
    assign range_x = max_x_reg - min_x_reg;
    assign range_y = max_y_reg - min_y_reg;
    assign dx      = ram_rdata[2*COORD_W-1:COORD_W] - min_x_reg;

    assign out_free = !out_valid_reg || !coord_stall;
    assign run_last = (idx_reg == count_reg - 1'b1);

    // Divider operand selection: u at start, v when u completes
    always_comb
    begin
        div_start = 1'b0;
        div_num   = dx;
        div_den   = rx_reg;
        if (state_reg == S_START)
        begin
            div_start = 1'b1;
        end
        else if (state_reg == S_DIV_U && div_done)
        begin
            div_start = 1'b1;
            div_num   = dy_reg;
            div_den   = ry_reg;
        end
    end

    // Sequencer and datapath next values
    always_comb
    begin
        state_next     = state_reg;
        min_x_next     = min_x_reg;
        max_x_next     = max_x_reg;
        min_y_next     = min_y_reg;
        max_y_next     = max_y_reg;
        count_next     = count_reg;
        drop_next      = drop_reg;
        idx_next       = idx_reg;
        rx_next        = rx_reg;
        ry_next        = ry_reg;
        dy_next        = dy_reg;
        u_next         = u_reg;
        out_valid_next = out_valid_reg && coord_stall;
        out_u_next     = out_u_reg;
        out_v_next     = out_v_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            S_LOAD:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        if (vertex_x < min_x_reg) min_x_next = vertex_x;
                        if (vertex_x > max_x_reg) max_x_next = vertex_x;
                        if (vertex_y < min_y_reg) min_y_next = vertex_y;
                        if (vertex_y > max_y_reg) max_y_next = vertex_y;
                    end
                    if (mesh_end)
                    begin
                        state_next = S_RANGE;
                    end
                end
            end
            S_RANGE:
            begin
                // A flat axis divides by 1.0; its numerators are all zero
                rx_next    = (range_x == '0) ? ONE_Q16 : range_x;
                ry_next    = (range_y == '0) ? ONE_Q16 : range_y;
                idx_next   = '0;
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                dy_next    = ram_rdata[COORD_W-1:0] - min_y_reg;
                state_next = S_DIV_U;
            end
            S_DIV_U:
            begin
                if (div_done)
                begin
                    u_next     = div_quot;
                    state_next = S_DIV_V;
                end
            end
            S_DIV_V:
            begin
                if (div_done)
                begin
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_u_next     = u_reg;
                    out_v_next     = div_quot;
                    out_last_next  = run_last;
                    out_ovf_next   = drop_reg;
                    if (run_last)
                    begin
                        // Mesh done: back to reset values
                        min_x_next = BOX_MIN_RESET;
                        max_x_next = BOX_MAX_RESET;
                        min_y_next = BOX_MIN_RESET;
                        max_y_next = BOX_MAX_RESET;
                        count_next = '0;
                        drop_next  = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            min_x_reg     <= BOX_MIN_RESET;
            max_x_reg     <= BOX_MAX_RESET;
            min_y_reg     <= BOX_MIN_RESET;
            max_y_reg     <= BOX_MAX_RESET;
            count_reg     <= '0;
            drop_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            min_x_reg     <= min_x_next;
            max_x_reg     <= max_x_next;
            min_y_reg     <= min_y_next;
            max_y_reg     <= max_y_next;
            count_reg     <= count_next;
            drop_reg      <= drop_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rx_reg       <= rx_next;
        ry_reg       <= ry_next;
        dy_reg       <= dy_next;
        u_reg        <= u_next;
        out_u_reg    <= out_u_next;
        out_v_reg    <= out_v_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign coord_valid = out_valid_reg;
    assign coord_u     = out_u_reg;
    assign coord_v     = out_v_reg;
    assign run_end     = out_last_reg;
    assign overflowed  = out_ovf_reg;

    // Store never counts past its depth
    assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("vertex count exceeds store depth");

    // Divider finishes only while the sequencer waits on it
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_DIV_U || state_reg == S_DIV_V))
        else $error("divider done outside a divide state");

    // Numerator never exceeds range, so a quotient is at most 1.0
    assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (div_quot <= UV_W'(ONE_Q16)))
        else $error("UV quotient above 1.0");

    // Emission reads only stored entries
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> (idx_reg < count_reg))
        else $error("store read beyond vertex count");

    // Handing off the last UV clears the mesh state
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PUSH && out_free && run_last)
        |=> (state_reg == S_LOAD && count_reg == '0 && !drop_reg && coord_valid && run_end))
        else $error("mesh state not cleared after last UV");

endmodule

@@ rtl/pubn_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module pubn_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/pubn_div.sv @@
// Restoring divider, one quotient bit per cycle: floor(num * 65536 / den), num <= den.
// Depends on pubn_pkg.
module pubn_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [pubn_pkg::COORD_W-1:0]  num,
    input  logic [pubn_pkg::COORD_W-1:0]  den,
    output logic                          done,
    output logic [pubn_pkg::UV_W-1:0]     quot
);
    import pubn_pkg::*;

    localparam int STEP_W = $clog2(DIV_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] cnt_reg, cnt_next;
    logic [COORD_W-1:0] rem_reg, rem_next;
    logic [COORD_W-1:0] den_reg, den_next;
    logic [UV_W-1:0]    quot_reg, quot_next;

    logic [COORD_W:0] trial;
    logic [COORD_W:0] diff;
    logic             fit;

    // One trial subtraction per cycle; first step has no shift (integer bit)
    always_comb
    begin
        if (cnt_reg == '0)
        begin
            trial = {1'b0, rem_reg};
        end
        else
        begin
            trial = {rem_reg, 1'b0};
        end
        diff = trial - {1'b0, den_reg};
        fit  = (trial >= {1'b0, den_reg});
    end

    // Step control
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quot_next = quot_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = num;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = fit ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
            quot_next = {quot_reg[UV_W-2:0], fit};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule
